>>> hw/rtl/mtfd_pkg.sv
// Package for the multi-tap feedback delay block.
// Holds the controller state type, register indexes, field widths and the
// command and status structs shared by the controller, datapath and top level.
`timescale 1ns / 1ps

package mtfd_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int FIELD_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int IN_DATA_W   = 3 * FIELD_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;
    localparam int COUNT_W     = 3;

    // Tap registers and the width of a tap select.
    localparam int TAP_REGS  = 4;
    localparam int TAP_SEL_W = 2;

    // Fields of a tap register.
    localparam int DELAY_W   = 24;
    localparam int FRAC_W    = 8;
    localparam int INT_W     = DELAY_W - FRAC_W;
    localparam int KEY_W     = INT_W + 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_0     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_1     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_2     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_3     = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_MAC,
        ST_FIN0,
        ST_FIN1,
        ST_COMMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 rd_next;
        logic                 interp0;
        logic                 interp1;
        logic                 mac;
        logic                 fin0;
        logic                 fin1;
        logic                 commit;
        logic [TAP_SEL_W-1:0] tap_sel;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [COUNT_W-1:0] active;
    } dp_status_t;

endpackage

>>> hw/rtl/multi_tap_feedback_delay.sv
// Top level of the multi-tap feedback delay: stream ports, configuration
// port, controller and datapath. Depends on mtfd_pkg, mtfd_ctrl, mtfd_datapath.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------
// s_       | in        | s_tvalid / s_tready  | in_sample, dry_gain, feedback_gain
// m_       | out       | m_tvalid / m_tready  | out_sample (tdata), clipped (tuser)
// cfg_     | in        | cfg_we               | cfg_index, cfg_data
//
// A transaction is accepted only in the idle state, so a new one is taken only
// once the previous one has committed; each tap needs two reads of the single
// history memory port, one interpolation step and one multiply-accumulate.
// Reset is asynchronous and active low; the history memory is not cleared,
// the fill count marks what has been written.
// A result waiting in the output register stalls only the commit step of the
// next transaction.
`timescale 1ns / 1ps

module multi_tap_feedback_delay
    import mtfd_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int TAPS        = 4,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // in_sample, dry_gain, feedback_gain
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [FIELD_W-1:0]     m_tdata,   // out_sample
    output logic [0:0]             m_tuser,   // clipped
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       clipped;

    // Sequencing of each transaction.
    mtfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, history memory and configuration.
    mtfd_datapath #(
        .DEPTH       (DEPTH),
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_sample     (s_tdata[FIELD_W-1:0]),
        .dry_gain      (s_tdata[2*FIELD_W-1:FIELD_W]),
        .feedback_gain (s_tdata[3*FIELD_W-1:2*FIELD_W]),
        .cmd           (cmd),
        .status        (status),
        .out_sample    (m_tdata),
        .clipped       (clipped)
    );

    assign m_tuser[0] = clipped;

endmodule

>>> hw/rtl/mtfd_ctrl.sv
// Controller state machine of the multi-tap feedback delay.
// Sequences tap reads, interpolation, accumulation and the final commit;
// depends on mtfd_pkg.
`timescale 1ns / 1ps

module mtfd_ctrl
    import mtfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t             state_reg;
    state_t             state_next;
    logic [COUNT_W-1:0] tap_cnt_reg;
    logic [COUNT_W-1:0] tap_cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // State, tap counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_cnt_reg   <= tap_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        tap_cnt_next = tap_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.tap_sel  = tap_cnt_reg[TAP_SEL_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load     = 1'b1;
                    tap_cnt_next = '0;
                    state_next   = (status.active == '0) ? ST_FIN0 : ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd_next = 1'b1;
                cmd.interp0 = 1'b1;
                state_next  = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.interp1 = 1'b1;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac = 1'b1;
                if (tap_cnt_reg + 1'b1 < status.active)
                begin
                    tap_cnt_next = tap_cnt_reg + 1'b1;
                    state_next   = ST_RD0;
                end
                else
                begin
                    state_next = ST_FIN0;
                end
            end
            ST_FIN0:
            begin
                cmd.fin0   = 1'b1;
                state_next = ST_FIN1;
            end
            ST_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // Wait for the output register to free up.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Output register valid: set by a commit, cleared when the result is taken.
    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    // A commit never overwrites a result that is still waiting.
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("commit while output register is full");

    // Tap accumulation only runs for active taps.
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (tap_cnt_reg < status.active))
        else $error("tap counter beyond active taps");

    // An accepted transaction always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start");

    // A commit always presents a result in the next cycle.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

>>> hw/rtl/mtfd_datapath.sv
// Datapath of the multi-tap feedback delay: configuration registers, the
// history memory, interpolation, tap accumulation, rounding and saturation.
// Depends on mtfd_pkg; driven by commands from mtfd_ctrl.
`timescale 1ns / 1ps

module mtfd_datapath
    import mtfd_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int TAPS        = 4,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic        [CFG_INDEX_W-1:0] cfg_index,
    input  logic        [CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [FIELD_W-1:0]     in_sample,
    input  logic signed [FIELD_W-1:0]     dry_gain,
    input  logic signed [FIELD_W-1:0]     feedback_gain,
    input  ctrl_cmd_t                     cmd,
    output dp_status_t                    status,
    output logic        [FIELD_W-1:0]     out_sample,
    output logic                          clipped
);

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = IW + 1;
    localparam int LW  = (CW > KEY_W) ? CW : KEY_W;
    localparam int VW  = SAMPLE_BITS + 10;
    localparam int PW  = VW + GAIN_W;
    localparam int AW  = PW + 3;
    localparam int DW  = 2 * FIELD_W + FRAC_W;
    localparam int SW  = ((AW > DW) ? AW : DW) + 1;
    localparam int YW  = SW - 22;
    localparam int FW  = YW + FIELD_W;
    localparam int RW  = FW - 15;
    localparam int STW = RW + 1;

    localparam logic [COUNT_W-1:0] ACTIVE_MAX = COUNT_W'((TAPS < TAP_REGS) ? TAPS : TAP_REGS);

    localparam logic signed [SW-1:0]  HALF22 = SW'(1) << 21;
    localparam logic signed [FW-1:0]  HALF15 = FW'(1) << 14;
    localparam logic signed [YW-1:0]  YMAX   = YW'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [YW-1:0]  YMIN   = -YMAX - YW'(1);
    localparam logic signed [STW-1:0] SMAX   = STW'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [STW-1:0] SMIN   = -SMAX - STW'(1);

    // Configuration registers.
    logic [COUNT_W-1:0]    tap_count_reg;
    logic [CFG_DATA_W-1:0] tap_cfg_reg [TAP_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= COUNT_W'(1);
            for (int i = 0; i < TAP_REGS; i++)
            begin
                tap_cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAP_COUNT: tap_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_TAP_0:     tap_cfg_reg[0] <= cfg_data;
                CFG_TAP_1:     tap_cfg_reg[1] <= cfg_data;
                CFG_TAP_2:     tap_cfg_reg[2] <= cfg_data;
                CFG_TAP_3:     tap_cfg_reg[3] <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign status.active = (tap_count_reg > ACTIVE_MAX) ? ACTIVE_MAX : tap_count_reg;

    // Decode of the selected tap; delays under one sample are raised to one.
    logic        [CFG_DATA_W-1:0] tap_word;
    logic        [DELAY_W-1:0]    delay_raw;
    logic        [DELAY_W-1:0]    delay;
    logic        [INT_W-1:0]      delay_int;
    logic        [FRAC_W-1:0]     delay_frac;
    logic signed [GAIN_W-1:0]     tap_gain;

    assign tap_word   = tap_cfg_reg[cmd.tap_sel];
    assign delay_raw  = tap_word[CFG_DATA_W-1:GAIN_W];
    assign tap_gain   = tap_word[GAIN_W-1:0];
    assign delay      = (delay_raw < DELAY_W'(256)) ? DELAY_W'(256) : delay_raw;
    assign delay_int  = delay[DELAY_W-1:FRAC_W];
    assign delay_frac = delay[FRAC_W-1:0];

    // Write pointer and fill count.
    logic [IW-1:0] wi_reg;
    logic [IW-1:0] wi_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;

    assign wi_next   = (wi_reg == IW'(DEPTH - 1)) ? '0 : wi_reg + 1'b1;
    assign fill_next = (fill_reg == CW'(DEPTH)) ? fill_reg : fill_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= '0;
            fill_reg <= '0;
        end
        else if (cmd.commit)
        begin
            wi_reg   <= wi_next;
            fill_reg <= fill_next;
        end
    end

    // History address: k samples back from the write pointer, valid up to fill.
    logic [KEY_W-1:0] hist_k;
    logic [LW-1:0]    hist_k_l;
    logic [LW-1:0]    wi_l;
    logic [LW-1:0]    idx_l;
    logic [IW-1:0]    rd_idx;
    logic             rd_valid;

    assign hist_k   = {1'b0, delay_int} + KEY_W'(cmd.rd_next);
    assign hist_k_l = LW'(hist_k);
    assign wi_l     = LW'(wi_reg);
    assign idx_l    = (wi_l >= hist_k_l) ? wi_l - hist_k_l : wi_l + LW'(DEPTH) - hist_k_l;
    assign rd_idx   = idx_l[IW-1:0];
    assign rd_valid = (hist_k_l <= LW'(fill_reg));

    // Result to store and its saturation flag, formed in the commit step.
    logic signed [SAMPLE_BITS-1:0] st_value;
    logic                          st_clip;

    // History memory with a registered read port.
    logic        [SAMPLE_BITS-1:0] store_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            store_mem[wi_reg] <= st_value;
        end
        rd_data_reg  <= store_mem[rd_idx];
        rd_valid_reg <= rd_valid;
    end

    // Linear interpolation between two neighboring history entries.
    logic signed [SAMPLE_BITS-1:0] hist;
    logic        [FRAC_W:0]        w0;
    logic signed [VW-1:0]          prod0;
    logic signed [VW-1:0]          prod1;
    logic signed [VW-1:0]          interp_reg;
    logic signed [PW-1:0]          tap_prod;
    logic signed [AW-1:0]          acc_reg;

    assign hist     = rd_valid_reg ? rd_data_reg : '0;
    assign w0       = (FRAC_W + 1)'(256) - {1'b0, delay_frac};
    assign prod0    = hist * $signed({1'b0, w0});
    assign prod1    = hist * $signed({2'b0, delay_frac});
    assign tap_prod = interp_reg * tap_gain;

    // Input capture, interpolation and tap accumulation.
    logic signed [FIELD_W-1:0]   x_reg;
    logic signed [FIELD_W-1:0]   fb_reg;
    logic signed [2*FIELD_W-1:0] dxp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= in_sample;
            fb_reg  <= feedback_gain;
            dxp_reg <= dry_gain * in_sample;
            acc_reg <= '0;
        end
        if (cmd.interp0)
        begin
            interp_reg <= prod0;
        end
        if (cmd.interp1)
        begin
            interp_reg <= interp_reg + prod1;
        end
        if (cmd.mac)
        begin
            acc_reg <= acc_reg + AW'(tap_prod);
        end
    end

    // Output sum and the tap sum, both rounded to Q1.15 units.
    logic signed [DW-1:0] dxp_sh;
    logic signed [SW-1:0] y_sum;
    logic signed [SW-1:0] t_sum;
    logic signed [YW-1:0] y_full;
    logic signed [YW-1:0] t_full;
    logic signed [YW-1:0] y_sat;
    logic                 y_clip;

    assign dxp_sh = {dxp_reg, {FRAC_W{1'b0}}};
    assign y_sum  = SW'(dxp_sh) + SW'(acc_reg) + HALF22;
    assign t_sum  = SW'(acc_reg) + HALF22;
    assign y_full = y_sum[SW-1:22];
    assign t_full = t_sum[SW-1:22];

    always_comb
    begin
        y_clip = 1'b1;
        priority if (y_full > YMAX)
            y_sat = YMAX;
        else if (y_full < YMIN)
            y_sat = YMIN;
        else
        begin
            y_sat  = y_full;
            y_clip = 1'b0;
        end
    end

    // Feedback product and the stored value.
    logic        [FIELD_W-1:0] y_out_reg;
    logic                      y_clip_reg;
    logic signed [YW-1:0]      t_reg;
    logic signed [FW-1:0]      fbt_reg;
    logic signed [FW-1:0]      fbt_sum;
    logic signed [RW-1:0]      fbt_rnd;
    logic signed [STW-1:0]     st_full;
    logic signed [STW-1:0]     st_sat;

    assign fbt_sum = fbt_reg + HALF15;
    assign fbt_rnd = fbt_sum[FW-1:15];
    assign st_full = STW'(x_reg) + STW'(fbt_rnd);

    always_comb
    begin
        st_clip = 1'b1;
        priority if (st_full > SMAX)
            st_sat = SMAX;
        else if (st_full < SMIN)
            st_sat = SMIN;
        else
        begin
            st_sat  = st_full;
            st_clip = 1'b0;
        end
    end

    assign st_value = st_sat[SAMPLE_BITS-1:0];

    // Final steps and the output register.
    logic [FIELD_W-1:0] out_sample_reg;
    logic               clipped_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fin0)
        begin
            y_out_reg  <= y_sat[FIELD_W-1:0];
            y_clip_reg <= y_clip;
            t_reg      <= t_full;
        end
        if (cmd.fin1)
        begin
            fbt_reg <= fb_reg * t_reg;
        end
        if (cmd.commit)
        begin
            out_sample_reg <= y_out_reg;
            clipped_reg    <= y_clip_reg | st_clip;
        end
    end

    assign out_sample = out_sample_reg;
    assign clipped    = clipped_reg;

endmodule

>>> sim/tb_multi_tap_feedback_delay.sv
// Self-checking testbench for the multi-tap feedback delay block.
// A directed plan and random phases are checked against a fixed-point echo predictor.
// Depends on mtfd_pkg and multi_tap_feedback_delay from the RTL.
`timescale 1ns / 1ps

module tb_multi_tap_feedback_delay
    import mtfd_pkg::*;
();

    localparam int DEPTH       = 65536;
    localparam int TAPS        = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int RUN_LIMIT   = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;

    // Indexes that decode to no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_5 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One step of the directed plan: a register write or one sample transaction.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [15:0]            x;
        logic [15:0]            dry;
        logic [15:0]            fb;
        logic                   known;
        logic [15:0]            want_out;
        logic                   want_clip;
    } plan_row_t;

    typedef struct packed {
        logic [15:0] sample;
        logic        clip;
    } echo_t;

    localparam int PLAN_ROWS = 34;

    // Rows with known = 1 carry a result that can be worked out by hand.
    plan_row_t plan [PLAN_ROWS] = '{
        // Direct path only, right after reset: extremes of sample and dry gain.
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h4000, 16'h0000, 1'b1, 16'h7FFF, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h8000, 16'h0000, 1'b1, 16'h7FFF, 1'b1},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h4000, 16'h0000, 1'b1, 16'h8000, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h0000, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
        '{ROW_ITEM, '0, '0, 16'hFFFF, 16'h0001, 16'h0000, 1'b1, 16'h0000, 1'b0},
        // One-sample delay at unity gain, then feedback into saturation.
        '{ROW_CFG, CFG_TAP_0, {24'h000100, 16'h4000}, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h1234, 16'h0000, 16'h0000, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h4000, 16'h8000, 1'b0, '0, 1'b0},
        // Fractional delay of 2.5 samples with the most negative gain.
        '{ROW_CFG, CFG_TAP_0, {24'h000280, 16'h8000}, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h0100, 16'h2000, 16'h4000, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h0000, 16'h8000, 1'b0, '0, 1'b0},
        // Delays below one sample are raised to one.
        '{ROW_CFG, CFG_TAP_0, {24'h000080, 16'h7FFF}, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h4000, 16'h0000, 16'h0000, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'hC000, 16'h4000, 16'h2000, 1'b0, '0, 1'b0},
        '{ROW_CFG, CFG_TAP_0, {24'h000000, 16'hC000}, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h0001, 16'h0000, 16'h7FFF, 1'b0, '0, 1'b0},
        // All taps, one past the written history, with an oversized tap count.
        '{ROW_CFG, CFG_TAP_1, {24'hFFFFFF, 16'h7FFF}, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, CFG_TAP_2, {24'h0003FF, 16'h8000}, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, CFG_TAP_3, {24'h000A40, 16'h4000}, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, CFG_TAP_COUNT, 40'h7, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h2000, 16'h1000, 16'h0800, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, '0, 1'b0},
        // No taps at all: the output is the dry path alone.
        '{ROW_CFG, CFG_TAP_COUNT, 40'h0, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h5555, 16'h4000, 16'h7FFF, 1'b1, 16'h5555, 1'b0},
        // Writes to unused indexes must change nothing.
        '{ROW_CFG, CFG_SPARE_5, 40'hFF_FFFF_FFFF, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, CFG_SPARE_7, 40'h00_0000_0001, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'hAAAA, 16'h4000, 16'h0000, 1'b1, 16'hAAAA, 1'b0},
        '{ROW_CFG, CFG_TAP_COUNT, 40'h3, '0, '0, '0, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h1357, 16'h2468, 16'hF00F, 1'b0, '0, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0, 1'b0}
    };

    // Block ports; every input starts at a known value.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;  // in_sample, dry_gain, feedback_gain
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [FIELD_W-1:0]     m_tdata;         // out_sample
    logic [0:0]             m_tuser;         // clipped
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor state: history, write pointer, fill level and register copies.
    logic signed [15:0] hist_mem [DEPTH];
    int unsigned        hist_wr    = 0;
    int unsigned        hist_fill  = 0;
    logic [COUNT_W-1:0] model_taps = 3'd1;
    logic [39:0]        model_tap [TAP_REGS] = '{default: '0};

    echo_t pending_echo [$];
    echo_t pin_want;
    bit    pin_valid      = 1'b0;
    bit    hold_req       = 1'b0;
    int    burst_left     = 0;
    int    mismatch_count = 0;
    int    cycle_count    = 0;

    multi_tap_feedback_delay #(
        .DEPTH       (DEPTH),
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Round half up: floor((v + 2^(s-1)) / 2^s) on a signed value.
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_sample(input longint v, inout bit hit);
        longint hi;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < -hi - 1)
        begin
            hit = 1'b1;
            return -hi - 1;
        end
        return v;
    endfunction

    // Sample stored k transactions ago; nothing written that far back reads zero.
    function automatic longint hist_at(input int unsigned k);
        if (k == 0 || k > hist_fill)
            return 0;
        return longint'(hist_mem[(hist_wr + DEPTH - k) % DEPTH]);
    endfunction

    // Works out the output of one sample and pushes the stored value into history.
    function automatic echo_t predict_echo(input logic signed [15:0] x,
                                           input logic signed [15:0] dry,
                                           input logic signed [15:0] fb);
        longint      acc, v, g, y, t, st;
        int unsigned act, dly, ip, fr;
        int          i;
        bit          hit;
        echo_t       res;
        acc = 0;
        hit = 1'b0;
        act = (model_taps > TAPS) ? TAPS : model_taps;
        for (i = 0; i < act; i++)
        begin
            dly = model_tap[i][39:16];
            g   = longint'($signed(model_tap[i][15:0]));
            if (dly < 256)
                dly = 256;
            ip  = dly >> 8;
            fr  = dly & 32'hFF;
            v   = hist_at(ip) * longint'(256 - fr) + hist_at(ip + 1) * longint'(fr);
            acc += v * g;
        end
        y  = clamp_sample(rnd_shift(longint'(dry) * longint'(x) * 256 + acc, 22), hit);
        t  = rnd_shift(acc, 22);
        st = clamp_sample(longint'(x) + rnd_shift(longint'(fb) * t, 15), hit);
        hist_mem[hist_wr] = st[15:0];
        hist_wr = (hist_wr + 1) % DEPTH;
        if (hist_fill < DEPTH)
            hist_fill++;
        res.sample = y[15:0];
        res.clip   = hit;
        return res;
    endfunction

    // Field values weighted toward the extremes and small magnitudes.
    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 255) - 128);
            3, 4:    return 16'($urandom_range(0, 32767) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    // Tap register: mostly delays inside the written history, some short or huge.
    function automatic logic [39:0] pick_tap();
        logic [23:0] dly;
        logic [15:0] g;
        case ($urandom_range(0, 9))
            0, 1:    dly = 24'($urandom_range(0, 255));
            2:       dly = 24'($urandom);
            3:       dly = 24'($urandom_range(0, 24'h01FFFF));
            default: dly = 24'($urandom_range(256, 48 * 256));
        endcase
        if ($urandom_range(0, 3) == 0)
            g = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else
            g = 16'($urandom);
        return {dly, g};
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one sample transaction and returns at the edge that takes it.
    // With gaps on, the sender idles between bursts of random length.
    task automatic offer(input logic [15:0] x, input logic [15:0] dry,
                         input logic [15:0] fb, input bit gaps_on);
        s_tvalid <= 1'b1;
        s_tdata  <= {fb, dry, x};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        pin_valid = 1'b0;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    // Holds the sender until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_echo.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sampled at the falling edge: values there are the ones the next rising edge takes.
    always @(negedge clk)
    begin : scoreboard
        echo_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TAP_COUNT)
                    model_taps = cfg_data[COUNT_W-1:0];
                else if (cfg_index >= CFG_TAP_0 && cfg_index <= CFG_TAP_3)
                    model_tap[cfg_index - CFG_TAP_0] = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_echo.size() == 0)
                begin
                    $error("result with no expectation: out_sample %0d, clipped %0d",
                           $signed(m_tdata), m_tuser[0]);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_echo.pop_front();
                    if (m_tdata !== want.sample)
                    begin
                        $error("out_sample: expected %0d, actual %0d",
                               $signed(want.sample), $signed(m_tdata));
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.clip)
                    begin
                        $error("clipped: expected %0d, actual %0d", want.clip, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_echo(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
                if (pin_valid)
                    want = pin_want;
                pending_echo.push_back(want);
            end
        end
    end

    // Receiver pacing: stretches of differing stall density, plus one long hold-off.
    initial
    begin : sink_pacing
        int stretch;
        int stall_pct;
        forever
        begin
            stretch = $urandom_range(8, 80);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (stretch)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        int phase;
        int i;
        logic [39:0] tap_val;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 16);

        // Directed plan; registers change only once the block has drained.
        for (r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(plan[r].reg_idx, plan[r].reg_val);
            end
            else
            begin
                pin_valid        = plan[r].known;
                pin_want.sample  = plan[r].want_out;
                pin_want.clip    = plan[r].want_clip;
                offer(plan[r].x, plan[r].dry, plan[r].fb, 1'b1);
            end
        end

        // Random phases, each with its own register setting.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:       write_reg(CFG_TAP_COUNT, 40'd4);
                1:       write_reg(CFG_TAP_COUNT, 40'd7);
                default: write_reg(CFG_TAP_COUNT,
                                   ($urandom_range(0, 2) != 0) ? 40'd4
                                                               : 40'($urandom_range(0, 7)));
            endcase
            for (i = 0; i < TAP_REGS; i++)
            begin
                if (phase == 0)
                    // Closely spaced short delays, all at the most negative gain.
                    tap_val = {24'h000100 + 24'(i * 128), 16'h8000};
                else if (phase == 1)
                    // Largest gains; the last tap at the longest delay.
                    tap_val = {(i == TAP_REGS - 1) ? 24'hFFFFFF : 24'h0000FF + 24'(i * 256),
                               16'h7FFF};
                else
                    tap_val = pick_tap();
                write_reg(CFG_TAP_0 + 3'(i), tap_val);
            end
            write_reg(CFG_TAP_3 + 3'($urandom_range(1, 3)), 40'({$urandom, $urandom}));

            // The receiver holds off while the sender keeps pushing back to back.
            if (phase == 3)
            begin
                hold_req = 1'b1;
                repeat (12) offer(pick_field(), pick_field(), pick_field(), 1'b0);
            end
            repeat (PHASE_ITEMS) offer(pick_field(), pick_field(), pick_field(), phase != 5);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
